// ===== rtl/core/cat_pkg.sv =====
// Shared types and constants for the client admission table.
`default_nettype none

package cat_pkg;

	localparam int KEY_W     = 32;
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int CNT_W     = 16;
	localparam int VERDICT_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [VERDICT_W-1:0] VERDICT_ADMIT = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_BUSY  = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_FULL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ADMIT_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY      = 2'd1;

	localparam logic [CFG_W-1:0] ADMIT_LIMIT_RESET = 16'd10;
	localparam logic [CFG_W-1:0] EXPIRY_RESET      = 16'd60;

	// One table entry as stored in memory.
	typedef struct packed {
		logic              valid;
		logic              admitted;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] last_seen;
	} entry_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} fsm_t;

	typedef struct packed {
		logic clear;
		logic eval;
	} scan_ctl_t;

	typedef struct packed {
		logic hit;
		logic hit_admitted;
		logic free;
		logic expire;
		logic expire_admitted;
	} scan_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/client_admission_table_core.sv =====
// Top level of the client admission table: control, configuration and result register.
//
//   Channel   Direction  Handshake              Payload
//   in        in         in_valid / in_stall    client_key, now_seconds
//   out       out        out_valid / out_stall  verdict, admitted_count
//   cfg       in         cfg_we                 cfg_index, cfg_data
//
// After its transfer, a request is swept with one read per entry through the table
// RAM's single read port; the read pipeline then drains, and a final step writes back
// and forms the verdict. The idle state takes the next request only once that step
// is done, so a new request is not taken while one is still being swept.
// After reset the RAM is cleared entry by entry; in_stall is high meanwhile.
// A stalled result holds the output register; the next request may still
// be taken and swept, and it waits in the final step until the register frees.
`default_nettype none

module client_admission_table_core #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [cat_pkg::KEY_W-1:0]       client_key,
	input  wire logic [cat_pkg::TIME_W-1:0]      now_seconds,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [cat_pkg::VERDICT_W-1:0]   verdict,
	output logic      [cat_pkg::CNT_W-1:0]       admitted_count,
	input  wire logic                            cfg_we,
	input  wire logic [cat_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cat_pkg::CFG_W-1:0]       cfg_data
);

	localparam int               IDX_W    = $clog2(TABLE_ENTRIES);
	localparam int               ENTRY_W  = $bits(cat_pkg::entry_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	cat_pkg::fsm_t state_q;
	cat_pkg::fsm_t state_d;

	logic [IDX_W-1:0]           rd_idx_q;
	logic                       rd_v_s1;
	logic [IDX_W-1:0]           idx_s1;
	logic [cat_pkg::KEY_W-1:0]  key_q;
	logic [cat_pkg::TIME_W-1:0] now_q;
	logic [cat_pkg::CNT_W-1:0]  live_q;
	logic [cat_pkg::CFG_W-1:0]  admit_limit_q;
	logic [cat_pkg::CFG_W-1:0]  expiry_q;
	logic                       out_valid_q;
	logic [cat_pkg::VERDICT_W-1:0] verdict_q;
	logic [cat_pkg::CNT_W-1:0]  count_q;

	logic                 in_xfer;
	logic                 out_free;
	logic                 ram_re;
	logic                 clr_we;
	logic                 done_fire;
	cat_pkg::scan_ctl_t   scan_ctl;
	cat_pkg::scan_flags_t flags;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     free_idx;
	cat_pkg::entry_t      rd_entry;
	logic [ENTRY_W-1:0]   rd_data;

	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	cat_pkg::entry_t            ram_wentry;
	logic                       already;
	logic                       admit_now;
	logic [cat_pkg::VERDICT_W-1:0] verdict_d;
	logic [cat_pkg::CNT_W-1:0]  count_d;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign rd_entry = cat_pkg::entry_t'(rd_data);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cat_pkg::ST_CLEAR: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = cat_pkg::ST_IDLE;
				end
			end
			cat_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = cat_pkg::ST_SCAN;
				end
			end
			cat_pkg::ST_SCAN: begin
				if (rd_idx_q == LAST_IDX) begin
					state_d = cat_pkg::ST_DRAIN;
				end
			end
			cat_pkg::ST_DRAIN: begin
				state_d = cat_pkg::ST_DONE;
			end
			cat_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = cat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cat_pkg::ST_CLEAR;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		in_stall       = 1'b1;
		ram_re         = 1'b0;
		clr_we         = 1'b0;
		done_fire      = 1'b0;
		scan_ctl.clear = 1'b0;
		scan_ctl.eval  = rd_v_s1;
		unique case (state_q)
			cat_pkg::ST_CLEAR: begin
				clr_we = 1'b1;
			end
			cat_pkg::ST_IDLE: begin
				in_stall       = 1'b0;
				scan_ctl.clear = 1'b1;
			end
			cat_pkg::ST_SCAN: begin
				ram_re = 1'b1;
			end
			cat_pkg::ST_DRAIN: begin
			end
			cat_pkg::ST_DONE: begin
				done_fire = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cat_pkg::ST_CLEAR;
			rd_idx_q <= '0;
			rd_v_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= ram_re;
			if (clr_we || ram_re) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (state_d == cat_pkg::ST_IDLE || state_d == cat_pkg::ST_DRAIN) begin
				rd_idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (in_xfer) begin
			key_q <= client_key;
			now_q <= now_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			admit_limit_q <= cat_pkg::ADMIT_LIMIT_RESET;
			expiry_q      <= cat_pkg::EXPIRY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cat_pkg::CFG_ADMIT_LIMIT: admit_limit_q <= cfg_data;
				cat_pkg::CFG_EXPIRY:      expiry_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Final decision for the request once the sweep is complete.
	always_comb begin
		already   = flags.hit && flags.hit_admitted;
		admit_now = 1'b0;
		verdict_d = cat_pkg::VERDICT_ADMIT;
		if (!flags.hit && !flags.free) begin
			verdict_d = cat_pkg::VERDICT_FULL;
		end else if (!already) begin
			if (live_q < admit_limit_q) begin
				admit_now = 1'b1;
			end else begin
				verdict_d = cat_pkg::VERDICT_BUSY;
			end
		end
		count_d = admit_now ? live_q + 1'b1 : live_q;
	end

	// Expiry write-backs happen during the sweep at the entry just read, never
	// at the entry being read, so the RAM needs no forwarding path.
	always_comb begin
		ram_we                = 1'b0;
		ram_waddr             = rd_idx_q;
		ram_wentry            = '0;
		ram_wentry.key        = key_q;
		ram_wentry.last_seen  = now_q;
		if (clr_we) begin
			ram_we = 1'b1;
		end else if (flags.expire) begin
			ram_we    = 1'b1;
			ram_waddr = idx_s1;
		end else if (done_fire && (flags.hit || flags.free)) begin
			ram_we              = 1'b1;
			ram_waddr           = flags.hit ? hit_idx : free_idx;
			ram_wentry.valid    = 1'b1;
			ram_wentry.admitted = already || admit_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (flags.expire_admitted && (live_q != '0)) begin
				live_q <= live_q - 1'b1;
			end else if (done_fire) begin
				live_q <= count_d;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			verdict_q <= verdict_d;
			count_q   <= count_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign admitted_count = count_q;

	cat_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	cat_scan #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx_s1   (idx_s1),
		.entry    (rd_entry),
		.key      (key_q),
		.now      (now_q),
		.expiry   (expiry_q),
		.flags    (flags),
		.hit_idx  (hit_idx),
		.free_idx (free_idx)
	);

endmodule

`default_nettype wire

// ===== rtl/core/cat_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module cat_ram #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cat_scan.sv =====
// Per-entry expiry check, key match and free-slot tracking during a table sweep.
`default_nettype none

module cat_scan #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire cat_pkg::scan_ctl_t               ctl,
	input  wire logic [$clog2(TABLE_ENTRIES)-1:0] idx_s1,
	input  wire cat_pkg::entry_t                  entry,
	input  wire logic [cat_pkg::KEY_W-1:0]        key,
	input  wire logic [cat_pkg::TIME_W-1:0]       now,
	input  wire logic [cat_pkg::CFG_W-1:0]        expiry,
	output cat_pkg::scan_flags_t                  flags,
	output logic      [$clog2(TABLE_ENTRIES)-1:0] hit_idx,
	output logic      [$clog2(TABLE_ENTRIES)-1:0] free_idx
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	logic [cat_pkg::TIME_W-1:0] idle;
	logic                       expired;
	logic                       live;
	logic                       hit_q;
	logic                       hit_adm_q;
	logic                       free_q;
	logic [IDX_W-1:0]           hit_idx_q;
	logic [IDX_W-1:0]           free_idx_q;

	// Idle time wraps modulo 2^32, so a clock that ran backwards reads as long idle.
	assign idle    = now - entry.last_seen;
	assign expired = entry.valid && (idle >= {{(cat_pkg::TIME_W-cat_pkg::CFG_W){1'b0}}, expiry});
	assign live    = entry.valid && !expired;

	// An expired entry is both removed and counted as a free slot in the same pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (ctl.eval) begin
			if (live && (entry.key == key) && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!live && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval && live && (entry.key == key) && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_adm_q <= entry.admitted;
		end
		if (ctl.eval && !live && !free_q) begin
			free_idx_q <= idx_s1;
		end
	end

	always_comb begin
		flags.hit             = hit_q;
		flags.hit_admitted    = hit_adm_q;
		flags.free            = free_q;
		flags.expire          = ctl.eval && expired;
		flags.expire_admitted = ctl.eval && expired && entry.admitted;
	end

	assign hit_idx  = hit_idx_q;
	assign free_idx = free_idx_q;

endmodule

`default_nettype wire

// ===== rtl/core/cat_checker.sv =====
// Port-level checks for the client admission table, bound to the top level.
`default_nettype none

module cat_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [cat_pkg::VERDICT_W-1:0] verdict,
	input wire logic [cat_pkg::CNT_W-1:0]     admitted_count
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(admitted_count))
		else $error("stalled result changed");

	// One request at a time: a transfer on the input closes it for the sweep.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

	// A result never appears in the cycle right after its request.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result too early");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == cat_pkg::VERDICT_ADMIT) || (verdict == cat_pkg::VERDICT_BUSY)
			|| (verdict == cat_pkg::VERDICT_FULL))
		else $error("undefined verdict");

endmodule

bind client_admission_table_core cat_checker u_cat_checker (.*);

`default_nettype wire
